// File: sv/sttd_pkg.sv
// ----------------------------------------------------------------------------
// sttd_pkg
// Shared types and constants of the sync/type/length deframer: phase and
// byte class codes, register indexes, reset values, the config and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package sttd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 3;

    // Register reset values
    localparam logic [BYTE_W-1:0] RST_SYNC_VALUE           = 8'hED;
    localparam logic [BYTE_W-1:0] RST_FIRST_TYPE_CODE      = 8'd68;
    localparam logic [BYTE_W-1:0] RST_FIRST_HEADER_LENGTH  = 8'd3;
    localparam logic [BYTE_W-1:0] RST_FIRST_LENGTH_OFFSET  = 8'd2;
    localparam logic [BYTE_W-1:0] RST_SECOND_TYPE_CODE     = 8'd79;
    localparam logic [BYTE_W-1:0] RST_SECOND_HEADER_LENGTH = 8'd1;
    localparam logic [BYTE_W-1:0] RST_SECOND_LENGTH_OFFSET = 8'd0;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_TYPE = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        CLS_STRAY  = 2'd0,
        CLS_SYNC   = 2'd1,
        CLS_FRAME  = 2'd2,
        CLS_REJECT = 2'd3
    } t_byte_class;

    typedef enum logic [INDEX_W-1:0] {
        REG_SYNC_VALUE           = 3'd0,
        REG_FIRST_TYPE_CODE      = 3'd1,
        REG_FIRST_HEADER_LENGTH  = 3'd2,
        REG_FIRST_LENGTH_OFFSET  = 3'd3,
        REG_SECOND_TYPE_CODE     = 3'd4,
        REG_SECOND_HEADER_LENGTH = 3'd5,
        REG_SECOND_LENGTH_OFFSET = 3'd6
    } t_reg_index;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_value;
        logic [BYTE_W-1:0] first_type_code;
        logic [BYTE_W-1:0] first_header_length;
        logic [BYTE_W-1:0] first_length_offset;
        logic [BYTE_W-1:0] second_type_code;
        logic [BYTE_W-1:0] second_header_length;
        logic [BYTE_W-1:0] second_length_offset;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] echo_byte;
        t_byte_class       byte_class;
        logic              kind_index;
        logic [BYTE_W-1:0] frame_position;
        logic              frame_last;
    } t_result;

endpackage

`default_nettype wire

// File: sv/sync_type_length_deframer_top.sv
// ----------------------------------------------------------------------------
// sync_type_length_deframer_top
// Sync/type/length deframer: classifies each received byte as stray, sync,
// frame byte or rejected type, with frame kind, position and last flag.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+---------------------------
//  s stream | in        | i_s_tvalid/o_s_tready  | i_s_tdata: data_byte
//  m stream | out       | o_m_tvalid/i_m_tready  | tdata, tuser, tlast
//  cfg      | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
//  Flow: one byte per clock sustained while the m stream does not stall; a
//  byte lands in the input register when accepted and then moves on to the
//  result register, from which its item is offered on the m stream.
//  The classifier state updates in the same cycle as the result register, so
//  consecutive bytes chain through it with no bubble.
//  Stalls: the result register is refilled in the cycle it is taken, so
//  o_s_tready stays high through back-to-back traffic; a stalled output
//  holds both registers and drops tready once the input register is full.
//  Reset: synchronous, active low; clears the valid flags, the hunting
//  state and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_type_length_deframer_top
    import sttd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [7:0]         i_s_tdata,   // [7:0] data_byte

    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [15:0]             o_m_tdata,   // [7:0] echo_byte, [15:8] frame_position
    output logic [2:0]              o_m_tuser,   // [1:0] byte_class, [2] kind_index
    output logic                    o_m_tlast,   // frame_last

    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [INDEX_W-1:0] i_cfg_index,
    input  wire logic [BYTE_W-1:0]  i_cfg_data
);

    t_cfg              cfg;
    t_result           result;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;

    logic              advance;     // move the input register into the result
    logic              in_take;

    // Writes go straight into the register file, so the port never stalls.
    assign o_cfg_ready = 1'b1;

    sttd_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Classify when the result register is free or being emptied this cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_take    = i_s_tvalid && o_s_tready;

    sttd_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_s_tdata;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.frame_position, r_out.echo_byte};
    assign o_m_tuser  = {r_out.kind_index, r_out.byte_class};
    assign o_m_tlast  = r_out.frame_last;

`ifndef NO_ASSERTIONS
    // backpressure on the input only when a byte is already parked
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_s_tready)
        else $error("input refused while input register empty");

    // a waiting byte moves on as soon as the result register frees up
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && i_m_tready) |=> o_m_tvalid)
        else $error("result register left empty with a byte waiting");

    // hold a refused item unchanged until the sink takes it
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("output item changed while stalled");
`endif

endmodule

`default_nettype wire

// File: sv/sttd_regs.sv
// ----------------------------------------------------------------------------
// sttd_regs
// Configuration register file: seven byte registers written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module sttd_regs
    import sttd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_wr_en,
    input  wire logic [INDEX_W-1:0] i_wr_index,
    input  wire logic [BYTE_W-1:0]  i_wr_data,
    output t_cfg                    o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_value           <= RST_SYNC_VALUE;
            r_cfg.first_type_code      <= RST_FIRST_TYPE_CODE;
            r_cfg.first_header_length  <= RST_FIRST_HEADER_LENGTH;
            r_cfg.first_length_offset  <= RST_FIRST_LENGTH_OFFSET;
            r_cfg.second_type_code     <= RST_SECOND_TYPE_CODE;
            r_cfg.second_header_length <= RST_SECOND_HEADER_LENGTH;
            r_cfg.second_length_offset <= RST_SECOND_LENGTH_OFFSET;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                REG_SYNC_VALUE:           r_cfg.sync_value           <= i_wr_data;
                REG_FIRST_TYPE_CODE:      r_cfg.first_type_code      <= i_wr_data;
                REG_FIRST_HEADER_LENGTH:  r_cfg.first_header_length  <= i_wr_data;
                REG_FIRST_LENGTH_OFFSET:  r_cfg.first_length_offset  <= i_wr_data;
                REG_SECOND_TYPE_CODE:     r_cfg.second_type_code     <= i_wr_data;
                REG_SECOND_HEADER_LENGTH: r_cfg.second_header_length <= i_wr_data;
                REG_SECOND_LENGTH_OFFSET: r_cfg.second_length_offset <= i_wr_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: sv/sttd_fsm.sv
// ----------------------------------------------------------------------------
// sttd_fsm
// Frame hunting state machine: classifies one byte per step and tracks
// the frame position and total length.
// ----------------------------------------------------------------------------
`default_nettype none

module sttd_fsm
    import sttd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  t_cfg                   i_cfg,
    output t_result                o_result
);

    t_phase            r_phase,       n_phase;
    logic [BYTE_W-1:0] r_bytes_taken, n_bytes_taken;
    logic [BYTE_W-1:0] r_frame_total, n_frame_total;
    logic              r_kind,        n_kind;

    logic              type_hit0;
    logic              type_hit1;
    logic              sync_hit;
    logic [BYTE_W-1:0] hdr_raw;
    logic [BYTE_W-1:0] hdr_len;
    logic [BYTE_W-1:0] len_offset;
    logic              len_here;
    logic [BYTE_W-1:0] len_sum;
    logic [BYTE_W-1:0] body_total;
    logic [BYTE_W:0]   pos_next;
    logic              body_last;

    // Shared decode of the current byte
    always_comb begin
        type_hit0  = (i_byte == i_cfg.first_type_code);
        type_hit1  = !type_hit0 && (i_byte == i_cfg.second_type_code);
        sync_hit   = (i_byte == i_cfg.sync_value);
        hdr_raw    = type_hit0 ? i_cfg.first_header_length : i_cfg.second_header_length;
        hdr_len    = (hdr_raw == '0) ? BYTE_W'(1) : hdr_raw;
        len_offset = r_kind ? i_cfg.second_length_offset : i_cfg.first_length_offset;
        len_here   = (len_offset != '0) && (len_offset < r_frame_total)
                     && (r_bytes_taken == len_offset);
        len_sum    = r_frame_total + i_byte;
        // a wrapped total never shortens the frame below its header
        body_total = (len_here && (len_sum > r_frame_total)) ? len_sum : r_frame_total;
        pos_next   = {1'b0, r_bytes_taken} + (BYTE_W+1)'(1);
        body_last  = (pos_next >= {1'b0, body_total});
    end

    // Next state
    always_comb begin
        n_phase       = r_phase;
        n_bytes_taken = r_bytes_taken;
        n_frame_total = r_frame_total;
        n_kind        = r_kind;
        unique case (r_phase)
            PH_TYPE: begin
                if (type_hit0 || type_hit1) begin
                    n_kind        = type_hit1;
                    n_frame_total = hdr_len;
                    n_bytes_taken = BYTE_W'(1);
                    n_phase       = (hdr_len == BYTE_W'(1)) ? PH_HUNT : PH_BODY;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_BODY: begin
                n_frame_total = body_total;
                n_bytes_taken = pos_next[BYTE_W-1:0];
                if (body_last) begin
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                n_phase = sync_hit ? PH_TYPE : PH_HUNT;
            end
        endcase
    end

    // Result
    always_comb begin
        o_result.echo_byte      = i_byte;
        o_result.byte_class     = CLS_STRAY;
        o_result.kind_index     = 1'b0;
        o_result.frame_position = '0;
        o_result.frame_last     = 1'b0;
        unique case (r_phase)
            PH_TYPE: begin
                if (type_hit0 || type_hit1) begin
                    o_result.byte_class = CLS_FRAME;
                    o_result.kind_index = type_hit1;
                    o_result.frame_last = (hdr_len == BYTE_W'(1));
                end else begin
                    o_result.byte_class = CLS_REJECT;
                end
            end
            PH_BODY: begin
                o_result.byte_class     = CLS_FRAME;
                o_result.kind_index     = r_kind;
                o_result.frame_position = r_bytes_taken;
                o_result.frame_last     = body_last;
            end
            default: begin
                o_result.byte_class = sync_hit ? CLS_SYNC : CLS_STRAY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_bytes_taken <= '0;
            r_frame_total <= '0;
            r_kind        <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_bytes_taken <= n_bytes_taken;
            r_frame_total <= n_frame_total;
            r_kind        <= n_kind;
        end
    end

`ifndef NO_ASSERTIONS
    // inside a frame body the position stays between the type byte and the end
    a_body_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_bytes_taken != '0) && (r_bytes_taken < r_frame_total))
        else $error("body position out of range");

    // the length field may only lengthen a frame
    a_total_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (r_phase == PH_BODY)) |=> (r_frame_total >= $past(r_frame_total)))
        else $error("frame total shrank inside a frame");

    a_last_only_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.frame_last |-> (o_result.byte_class == CLS_FRAME))
        else $error("last flag on a byte outside a frame");
`endif

endmodule

`default_nettype wire
